// ----- src/scafp_pkg.sv -----
// shared types and constants for the sum-checked answer frame parser
// used by scafp_front, scafp_back and the top level; no dependencies
`default_nettype none

package scafp_pkg;

   localparam logic [7:0]  START_BYTE   = 8'h53;
   localparam logic [7:0]  READ_CMD     = 8'h52;
   localparam logic [15:0] FIXED_ADDR   = 16'h3008;
   localparam logic [7:0]  ANSWER_WORDS = 8'h05;
   localparam logic [7:0]  FIXED_WORDS  = 8'h01;

   localparam int HEADER_AND_SUM_BYTES = 6;
   localparam int MIN_SCAN             = 8;
   localparam int WORD_NUM             = 5;
   localparam int TAP_NUM              = 16;

   localparam logic [4:0] SHORT_LEN   = 5'(HEADER_AND_SUM_BYTES + 2);
   localparam logic [4:0] LONG_LEN    = 5'(HEADER_AND_SUM_BYTES + 2 * WORD_NUM);
   localparam logic [4:0] MAX_RESULTS = 5'd16;
   localparam logic [2:0] SHORT_COUNT = 3'd1;
   localparam logic [2:0] LONG_COUNT  = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SUM,
      ST_CHECK,
      ST_DROP,
      ST_END
   } scafp_state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } scafp_byte_type;

   typedef struct packed {
      logic                       kind;
      logic [15:0]                addr;
      logic [2:0]                 count;
      logic [WORD_NUM-1:0][15:0]  words;
      logic                       last;
   } scafp_result_type;

endpackage

`default_nettype wire

// ----- src/scafp_front.sv -----
// receive side: two-entry byte queue between the link and the frame scanner
// depends on scafp_pkg
`default_nettype none

module scafp_front import scafp_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire logic [7:0]     in_data,
   output scafp_byte_type      byte_out,
   input  wire logic           byte_ready
);

   logic [7:0] mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready       = (count_ff != 2'd2);
   assign push           = in_valid & in_ready;
   assign pop            = byte_out.valid & byte_ready;
   assign byte_out.valid = (count_ff != 2'd0);
   assign byte_out.data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

// ----- src/scafp_back.sv -----
// frame scanner: byte window, header check, serial checksum and result register
// depends on scafp_pkg; fed by scafp_front
`default_nettype none

module scafp_back import scafp_pkg::*; #(
   parameter int WINDOW_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire scafp_byte_type   byte_in,
   output logic                  byte_ready,
   input  wire logic             csr_valid,
   input  wire logic [15:0]      csr_data,
   output scafp_result_type      rsp_out,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready
);

   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int IDX_W  = $clog2(WINDOW_DEPTH);
   localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(WINDOW_DEPTH);
   localparam logic [FILL_W-1:0] MIN_FILL   = FILL_W'(MIN_SCAN);

   scafp_state_type   state_ff, state_in;
   logic [7:0]        win_ff [WINDOW_DEPTH];
   logic [7:0]        win_in [WINDOW_DEPTH];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [7:0]        sum_ff, sum_in;
   logic [4:0]        nres_ff, nres_in;
   logic              pend_valid_ff, pend_valid_in;
   scafp_result_type  pend_ff, pend_in;
   logic              out_valid_ff, out_valid_in;
   scafp_result_type  out_ff, out_in;
   logic [15:0]       answer_ff;

   logic [7:0]        taps [TAP_NUM];
   logic              head_is_start, hdr_long, hdr_short, hdr_ok, sum_ok, out_free;
   logic              pend_stall, do_shift, do_append;
   logic [15:0]       head_addr;
   logic [4:0]        frame_len;
   logic [7:0]        check_byte;
   scafp_result_type  good_res, err_res;

   for (genvar g = 0; g < TAP_NUM; g++) begin : g_taps
      assign taps[g] = win_ff[g];
   end

   assign head_is_start = (win_ff[0] == START_BYTE);
   assign head_addr     = {win_ff[4], win_ff[3]};
   assign hdr_long      = (win_ff[2] == READ_CMD) && (head_addr == answer_ff) &&
                          (win_ff[1] == ANSWER_WORDS);
   assign hdr_short     = (win_ff[2] == READ_CMD) && (head_addr == FIXED_ADDR) &&
                          (win_ff[1] == FIXED_WORDS);
   assign hdr_ok        = hdr_long | hdr_short;
   assign frame_len     = hdr_long ? LONG_LEN : SHORT_LEN;
   assign check_byte    = hdr_long ? win_ff[15] : win_ff[7];
   assign sum_ok        = (sum_ff == check_byte);
   assign out_free      = !out_valid_ff || rsp_ready;
   assign pend_stall    = pend_valid_ff && !out_free;
   assign byte_ready    = (state_ff == ST_IDLE);

   always_comb begin
      good_res          = '0;
      good_res.kind     = 1'b0;
      good_res.addr     = head_addr;
      good_res.count    = hdr_long ? LONG_COUNT : SHORT_COUNT;
      good_res.words[0] = {win_ff[6], win_ff[5]};
      if (hdr_long) begin
         for (int i = 1; i < WORD_NUM; i++) begin
            good_res.words[i] = {win_ff[6 + 2 * i], win_ff[5 + 2 * i]};
         end
      end
      err_res      = '0;
      err_res.kind = 1'b1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (byte_in.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (fill_ff != '0 && !head_is_start) begin
               state_in = ST_SCAN;
            end else if (fill_ff < MIN_FILL) begin
               state_in = ST_END;
            end else if (!hdr_ok) begin
               state_in = ST_SCAN;
            end else if (fill_ff < FILL_W'(frame_len)) begin
               state_in = ST_END;
            end else begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (cnt_ff == frame_len - 5'd2) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (pend_stall) begin
               state_in = ST_CHECK;
            end else if (sum_ok) begin
               state_in = ST_DROP;
            end else if (nres_ff == MAX_RESULTS - 5'd1) begin
               state_in = ST_END;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_DROP: begin
            if (cnt_ff == 5'd1) begin
               state_in = (nres_ff == MAX_RESULTS) ? ST_END : ST_SCAN;
            end
         end
         ST_END: begin
            if (!pend_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      nres_in       = nres_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;
      do_shift      = 1'b0;
      do_append     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (byte_in.valid) begin
               do_append     = 1'b1;
               nres_in       = '0;
               pend_valid_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (fill_ff != '0 && !head_is_start) begin
               do_shift = 1'b1;
            end else if (fill_ff >= MIN_FILL && !hdr_ok) begin
               do_shift = 1'b1;
            end else begin
               cnt_in = '0;
               sum_in = '0;
            end
         end
         ST_SUM: begin
            sum_in = sum_ff + taps[cnt_ff[3:0]];
            cnt_in = cnt_ff + 5'd1;
         end
         ST_CHECK: begin
            if (!pend_stall) begin
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_in       = pend_ff;
                  out_in.last  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_in       = sum_ok ? good_res : err_res;
               nres_in       = nres_ff + 5'd1;
               if (sum_ok) begin
                  cnt_in = frame_len;
               end else begin
                  do_shift = 1'b1;
               end
            end
         end
         ST_DROP: begin
            do_shift = 1'b1;
            cnt_in   = cnt_ff - 5'd1;
         end
         ST_END: begin
            if (pend_valid_ff && out_free) begin
               out_valid_in  = 1'b1;
               out_in        = pend_ff;
               out_in.last   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
            pend_valid_in = 1'b0;
         end
      endcase
   end

   // window shift line
   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      if (do_shift || (do_append && fill_ff == DEPTH_FILL)) begin
         for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
      end
      if (do_append) begin
         if (fill_ff == DEPTH_FILL) begin
            win_in[WINDOW_DEPTH - 1] = byte_in.data;
         end else begin
            win_in[fill_ff[IDX_W-1:0]] = byte_in.data;
            fill_in = fill_ff + FILL_W'(1);
         end
      end else if (do_shift) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         nres_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         answer_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         nres_ff       <= nres_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         if (csr_valid) begin
            answer_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      cnt_ff  <= cnt_in;
      sum_ff  <= sum_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_out   = out_ff;
   assign rsp_valid = out_valid_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_FILL)
      else $error("window fill beyond depth");
   a_result_limit: assert property (@(posedge clock) disable iff (reset)
      nres_ff <= MAX_RESULTS)
      else $error("too many results for one byte");
   a_drop_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DROP |-> cnt_ff != 5'd0)
      else $error("drop with zero count");
   a_sum_frame_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> fill_ff >= FILL_W'(frame_len))
      else $error("checksum over incomplete frame");
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("pending result left when idle");
`endif

endmodule

`default_nettype wire

// ----- src/sum_checked_answer_frame_parser_unit.sv -----
// Sum-checked answer frame parser. Received bytes enter a two-entry queue and are
// moved one at a time into a sliding window; after each byte the scanner drops
// leading non-start bytes and bad headers, accumulates the checksum one byte per
// cycle, checks it and removes a good frame one byte per cycle. Results leave
// through an output register; the last result caused by one byte carries tlast.
// answer_address must be written on the csr channel only while idle; the block
// itself does not enforce this.
// depends on scafp_pkg, scafp_front and scafp_back
`default_nettype none

module sum_checked_answer_frame_parser_unit import scafp_pkg::*; #(
   parameter int WINDOW_DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // rx_byte
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [103:0]       rsp_tdata,   // frame_address, word_count, word_a .. word_e
   output logic               rsp_tuser,   // kind
   output logic               rsp_tlast,   // last
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [15:0]   csr_data     // answer_address
);

   scafp_byte_type   byte_link;
   logic             byte_ready;
   scafp_result_type rsp_res;

   scafp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .byte_out   (byte_link),
      .byte_ready (byte_ready)
   );

   scafp_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .byte_in    (byte_link),
      .byte_ready (byte_ready),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_out    (rsp_res),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready)
   );

   assign csr_ready = 1'b1;
   assign rsp_tuser = rsp_res.kind;
   assign rsp_tlast = rsp_res.last;
   assign rsp_tdata = {5'b0, rsp_res.words[4], rsp_res.words[3], rsp_res.words[2],
                       rsp_res.words[1], rsp_res.words[0], rsp_res.count, rsp_res.addr};

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// self-checking testbench for sum_checked_answer_frame_parser_unit: byte streams of good,
// corrupted, truncated and broken frames go in; every result transfer is checked against
// a frame predictor kept here. depends on scafp_pkg and the parser top level
`default_nettype none

module testbench;
   import scafp_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 300;
   localparam int PHASE_BYTES   = 70;
   localparam int PHASE_FRAMES  = 4;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata  = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;
   logic          rsp_tuser;
   logic          rsp_tlast;
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   logic [15:0]   csr_data   = '0;

   int sender_idle_pct  = 0;
   int stall_pct        = 0;
   int mismatches       = 0;
   int quiet_cycles     = 0;
   int bytes_sent       = 0;
   int frames_predicted = 0;

   logic [7:0]        rx_window [TAP_NUM];
   int                window_fill = 0;
   logic [15:0]       answer_reg  = '0;
   scafp_result_type  expected_frames [$];
   logic [7:0]        tx_bytes [$];
   string             word_names [WORD_NUM] = '{"word_a", "word_b", "word_c", "word_d", "word_e"};

   sum_checked_answer_frame_parser_unit #(.WINDOW_DEPTH(16)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // frame predictor
   function automatic void drop_bytes(int k);
      if (k >= window_fill) begin
         window_fill = 0;
      end else begin
         for (int i = 0; i < window_fill - k; i++) rx_window[i] = rx_window[i + k];
         window_fill -= k;
      end
   endfunction

   function automatic void predict_frames(logic [7:0] b);
      int               produced;
      int               total;
      logic [7:0]       cnt;
      logic [7:0]       sum;
      logic [15:0]      addr;
      logic             ok;
      logic             have_held;
      scafp_result_type r;
      scafp_result_type held;
      produced  = 0;
      have_held = 1'b0;
      held      = '0;
      if (window_fill >= TAP_NUM) drop_bytes(1);
      rx_window[window_fill] = b;
      window_fill++;
      while (produced < int'(MAX_RESULTS)) begin
         while (window_fill > 0 && rx_window[0] != START_BYTE) drop_bytes(1);
         if (window_fill < MIN_SCAN) break;
         cnt  = rx_window[1];
         addr = {rx_window[4], rx_window[3]};
         ok   = (rx_window[2] == READ_CMD) &&
                ((addr == answer_reg && cnt == ANSWER_WORDS) ||
                 (addr == FIXED_ADDR && cnt == FIXED_WORDS));
         if (!ok) begin
            drop_bytes(1);
            continue;
         end
         total = HEADER_AND_SUM_BYTES + 2 * int'(cnt);
         if (window_fill < total) break;
         sum = '0;
         for (int i = 0; i < total - 1; i++) sum += rx_window[i];
         r = '0;
         if (sum != rx_window[total - 1]) begin
            r.kind = 1'b1;
            drop_bytes(1);
         end else begin
            r.addr  = addr;
            r.count = cnt[2:0];
            for (int i = 0; i < int'(cnt); i++)
               r.words[i] = {rx_window[HEADER_AND_SUM_BYTES + 2 * i],
                             rx_window[HEADER_AND_SUM_BYTES - 1 + 2 * i]};
            drop_bytes(total);
         end
         if (have_held) expected_frames.push_back(held);
         held      = r;
         have_held = 1'b1;
         produced++;
         frames_predicted++;
      end
      if (have_held) begin
         held.last = 1'b1;
         expected_frames.push_back(held);
      end
   endfunction

   // byte stream building
   function automatic void add_raw(logic [63:0] bytes, int n);
      for (int i = 0; i < n; i++) tx_bytes.push_back(bytes[8 * i +: 8]);
   endfunction

   function automatic void add_sum(int from, logic [7:0] flip);
      logic [7:0] sum;
      sum = '0;
      for (int i = from; i < tx_bytes.size(); i++) sum += tx_bytes[i];
      tx_bytes.push_back(sum ^ flip);
   endfunction

   function automatic void add_frame(logic [15:0] addr, logic [7:0] cnt,
                                     logic [WORD_NUM-1:0][15:0] words, logic [7:0] flip);
      int from;
      from = tx_bytes.size();
      add_raw({24'd0, addr, READ_CMD, cnt, START_BYTE}, 5);
      for (int i = 0; i < int'(cnt); i++) add_raw({48'd0, words[i]}, 2);
      add_sum(from, flip);
   endfunction

   function automatic logic [7:0] noise_byte();
      if ($urandom_range(99) < 15) return START_BYTE;
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] rand_word();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 16'h0000;
      if (pick == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // transfers
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      predict_frames(b);
   endtask

   task automatic send_queued();
      foreach (tx_bytes[i]) send_byte(tx_bytes[i]);
      tx_bytes.delete();
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_answer_address(input logic [15:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      answer_reg = value;
   endtask

   // result checking
   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic check_result();
      scafp_result_type want;
      if (expected_frames.size() == 0) begin
         $error("result with nothing expected: tdata %h tuser %b tlast %b",
                rsp_tdata, rsp_tuser, rsp_tlast);
         mismatches++;
      end else begin
         want = expected_frames.pop_front();
         compare_field("kind", 16'(want.kind), 16'(rsp_tuser));
         compare_field("frame_address", want.addr, rsp_tdata[15:0]);
         compare_field("word_count", 16'(want.count), 16'(rsp_tdata[18:16]));
         for (int i = 0; i < WORD_NUM; i++)
            compare_field(word_names[i], want.words[i], rsp_tdata[19 + 16 * i +: 16]);
         compare_field("last", 16'(want.last), 16'(rsp_tlast));
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) check_result();
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // tests
   task automatic test_default_answer_address();
      add_frame(16'h0000, ANSWER_WORDS,
                {16'hA55A, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 8'h00);
      send_queued();
   endtask

   task automatic test_frame_special_cases();
      write_answer_address(16'hFFFF);
      // leading garbage, then a fixed-address frame
      add_raw({40'd0, 8'h52, 8'hFF, 8'h00}, 3);
      add_frame(FIXED_ADDR, FIXED_WORDS, {64'd0, 16'hFFFF}, 8'h00);
      // stale answer address, wrong command, wrong count for the fixed address
      add_raw({24'h111111, 16'h0000, READ_CMD, ANSWER_WORDS, START_BYTE}, 8);
      add_raw({24'h222222, FIXED_ADDR, 8'h51, FIXED_WORDS, START_BYTE}, 8);
      add_raw({24'h333333, FIXED_ADDR, READ_CMD, ANSWER_WORDS, START_BYTE}, 8);
      add_frame(16'hFFFF, ANSWER_WORDS,
                {16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE, 16'hFFFF}, 8'h00);
      // corrupted answer frame hiding a fixed frame: error then good on one byte
      add_raw({24'd0, 16'hFFFF, READ_CMD, ANSWER_WORDS, START_BYTE}, 5);
      add_frame(FIXED_ADDR, FIXED_WORDS, {64'd0, 16'h1234}, 8'h00);
      add_raw({48'd0, 16'h0102}, 2);
      add_sum(tx_bytes.size() - 15, 8'h80);
      send_queued();
   endtask

   task automatic test_traffic(input int idle, input int stall, input logic [15:0] addr);
      int                        byte_mark;
      int                        frame_mark;
      int                        pick;
      int                        n;
      logic [7:0]                cnt;
      logic [WORD_NUM-1:0][15:0] w;
      write_answer_address(addr);
      sender_idle_pct = idle;
      stall_pct       = stall;
      byte_mark  = bytes_sent;
      frame_mark = frames_predicted;
      while (bytes_sent - byte_mark < PHASE_BYTES || frames_predicted - frame_mark < PHASE_FRAMES)
      begin
         for (int i = 0; i < WORD_NUM; i++) w[i] = rand_word();
         pick = $urandom_range(99);
         if (pick < 40) begin
            add_frame(answer_reg, ANSWER_WORDS, w, 8'h00);
         end else if (pick < 62) begin
            add_frame(FIXED_ADDR, FIXED_WORDS, w, 8'h00);
         end else if (pick < 74) begin
            cnt = ($urandom_range(1)) ? ANSWER_WORDS : FIXED_WORDS;
            add_frame((cnt == ANSWER_WORDS) ? answer_reg : FIXED_ADDR, cnt, w,
                      8'($urandom_range(1, 255)));
         end else if (pick < 83) begin
            // truncated frame followed by whatever comes next
            add_raw({24'd0, answer_reg, READ_CMD, ANSWER_WORDS, START_BYTE}, 5);
            n = $urandom_range(9);
            for (int i = 0; i < n; i++) tx_bytes.push_back(noise_byte());
         end else if (pick < 92) begin
            // near-miss header
            case ($urandom_range(3))
               0: cnt = FIXED_WORDS;
               1: cnt = ANSWER_WORDS;
               default: cnt = 8'($urandom);
            endcase
            add_raw({24'd0, 16'($urandom_range(1) ? 16'($urandom) : FIXED_ADDR),
                     ($urandom_range(1) ? READ_CMD : 8'($urandom)), cnt, START_BYTE}, 5);
            n = $urandom_range(3, 12);
            for (int i = 0; i < n; i++) tx_bytes.push_back(noise_byte());
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) tx_bytes.push_back(noise_byte());
         end
         send_queued();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_answer_address();
      test_frame_special_cases();
      test_traffic(0, 0, FIXED_ADDR);
      test_traffic(82, 0, 16'($urandom));
      test_traffic(0, 82, 16'h0000);
      test_traffic(13, 13, 16'hFFFF);
      wait_idle();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/scafp_pkg.sv
src/scafp_front.sv
src/scafp_back.sv
src/sum_checked_answer_frame_parser_unit.sv
test/testbench.sv
